@@ sv/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// Periodic task timer table: shared definitions
// Sizes, operation and result codes, and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

   // Table geometry.
   localparam int NUM_SLOTS   = 16;
   localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int MAX_RESULTS = 16;
   localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

   // Field widths.
   localparam int GRAN_W    = 6;
   localparam int MODE_W    = 3;
   localparam int ID_W      = 4;
   localparam int IVAL_W    = 16;
   localparam int NOW_W     = 32;
   localparam int KIND_W    = 2;
   localparam int PER_W     = 26;
   localparam int PER20_W   = 31;
   localparam int REM_W     = GRAN_W + 1;
   localparam int DIV_CNT_W = $clog2(IVAL_W);

   // Stream data widths, rounded up to whole bytes.
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 8;

   // Constants of the arithmetic.
   localparam logic [GRAN_W-1:0] GRAN_RESET     = GRAN_W'(1);
   localparam logic [9:0]        MS_PER_S       = 10'd1000;
   localparam logic [4:0]        STRETCH_FACTOR = 5'd20;

   // Operation codes of an input item.
   localparam logic [MODE_W-1:0] MODE_ADD     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ENABLE  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DISABLE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_TICK    = 3'd4;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ENDIS  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              load;          // capture the request item
      logic              div_step;      // one remainder step
      logic              sub_en;        // round the interval down
      logic              mul_en;        // seconds to milliseconds
      logic              str_en;        // stretched period
      logic [SLOT_W-1:0] idx;           // slot under scan
      logic              slot_add;      // write a new task into the slot
      logic              slot_remove;   // free the slot
      logic              slot_enable;   // arm the slot
      logic              slot_disable;  // disarm the slot
      logic              slot_fire;     // fire and rearm the slot
      logic              set_ok;        // add or remove succeeded
      logic              push_ack;      // send the acknowledge item
      logic              push_fire;     // send the held fired item, not last
      logic              push_final;    // send the held fired item as last
   } ptt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [MODE_W-1:0] req_mode;      // mode of the item on the input
      logic [MODE_W-1:0] mode;          // mode of the item in work
      logic              paused;
      logic              cur_used;
      logic              cur_enabled;
      logic              cur_match;
      logic              cur_due;
      logic              pend_valid;
      logic              fire_full;
      logic              out_free;
   } ptt_stat_type;

endpackage

`default_nettype wire

@@ sv/ptt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Periodic task timer table: controller
// Sequences the interval rounding and the slot scan of each item and
// decides when results may enter the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   input  ptt_pkg::ptt_stat_type    stat,
   output ptt_pkg::ptt_cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_SUB   = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_STR   = 3'd4;
   localparam logic [2:0] ST_SCAN  = 3'd5;
   localparam logic [2:0] ST_ACK   = 3'd6;
   localparam logic [2:0] ST_FLUSH = 3'd7;

   localparam logic [ptt_pkg::SLOT_W-1:0] LAST_SLOT =
      ptt_pkg::SLOT_W'(ptt_pkg::NUM_SLOTS - 1);
   localparam logic [ptt_pkg::DIV_CNT_W-1:0] DIV_LAST =
      ptt_pkg::DIV_CNT_W'(ptt_pkg::IVAL_W - 1);

   logic [2:0]                        state_ff, state_in;
   logic [ptt_pkg::SLOT_W-1:0]        idx_ff, idx_in;
   logic [ptt_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                              advance;
   logic                              fire_hit;
   logic                              last_slot;

   // Slot scan helpers.
   assign last_slot = (idx_ff == LAST_SLOT);
   assign fire_hit  = stat.cur_used & stat.cur_enabled & stat.cur_due & ~stat.fire_full;

   // Next state and commands.
   always_comb begin
      cmd        = '0;
      cmd.idx    = idx_ff;
      state_in   = state_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      advance    = 1'b0;
      req_tready = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               cnt_in   = '0;
               case (stat.req_mode)
                  ptt_pkg::MODE_ADD: state_in = ST_DIV;
                  ptt_pkg::MODE_REMOVE, ptt_pkg::MODE_ENABLE,
                  ptt_pkg::MODE_DISABLE, ptt_pkg::MODE_TICK: state_in = ST_SCAN;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            cmd.sub_en = 1'b1;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_STR;
         end
         ST_STR: begin
            cmd.str_en = 1'b1;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            case (stat.mode)
               ptt_pkg::MODE_ADD: begin
                  if (!stat.cur_used) begin
                     cmd.slot_add = 1'b1;
                     cmd.set_ok   = 1'b1;
                     state_in     = ST_ACK;
                  end else if (last_slot) begin
                     state_in = ST_ACK;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               ptt_pkg::MODE_REMOVE: begin
                  if (stat.cur_used && stat.cur_match) begin
                     cmd.slot_remove = 1'b1;
                     cmd.set_ok      = 1'b1;
                     state_in        = ST_ACK;
                  end else if (last_slot) begin
                     state_in = ST_ACK;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               ptt_pkg::MODE_ENABLE: begin
                  cmd.slot_enable = stat.cur_used;
                  advance         = 1'b1;
               end
               ptt_pkg::MODE_DISABLE: begin
                  cmd.slot_disable = stat.cur_used;
                  advance          = 1'b1;
               end
               ptt_pkg::MODE_TICK: begin
                  if (stat.paused) begin
                     cmd.slot_disable = stat.cur_used;
                     advance          = 1'b1;
                  end else if (fire_hit) begin
                     // A held item must leave before a new one takes its place.
                     if (!stat.pend_valid || stat.out_free) begin
                        cmd.slot_fire = 1'b1;
                        cmd.push_fire = stat.pend_valid;
                        advance       = 1'b1;
                     end
                  end else begin
                     advance = 1'b1;
                  end
               end
               default: state_in = ST_IDLE;
            endcase

            // Step to the next slot, or end the full sweep for enable, disable and tick.
            if (advance) begin
               if (!last_slot) begin
                  idx_in = idx_ff + 1'b1;
               end else if (stat.mode == ptt_pkg::MODE_TICK) begin
                  state_in = stat.paused ? ST_IDLE : ST_FLUSH;
               end else begin
                  state_in = ST_ACK;
               end
            end
         end
         ST_ACK: begin
            if (stat.out_free) begin
               cmd.push_ack = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (!stat.pend_valid) begin
               state_in = ST_IDLE;
            end else if (stat.out_free) begin
               cmd.push_final = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/ptt_dp.sv @@
// ----------------------------------------------------------------------------
// Periodic task timer table: datapath
// Holds the granularity register, the item in work, the interval rounding
// unit, the slot table, the held fired item and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_dp (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_wr_en,
   input  wire  [ptt_pkg::GRAN_W-1:0]            csr_wr_data,
   input  wire  [ptt_pkg::REQ_TDATA_W-1:0]       req_tdata,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [ptt_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tlast,
   input  ptt_pkg::ptt_cmd_type                  cmd,
   output ptt_pkg::ptt_stat_type                 stat
);

   // Fields of the request item.
   logic [ptt_pkg::MODE_W-1:0]  req_mode;
   logic [ptt_pkg::ID_W-1:0]    req_id;
   logic [ptt_pkg::IVAL_W-1:0]  req_ival;
   logic                        req_slow;
   logic [ptt_pkg::NOW_W-1:0]   req_now;
   logic                        req_conn;
   logic                        req_paused;

   // Configuration and the item in work.
   logic [ptt_pkg::GRAN_W-1:0]  gran_ff;
   logic [ptt_pkg::GRAN_W-1:0]  gran_eff;
   logic [ptt_pkg::IVAL_W-1:0]  raised;
   logic [ptt_pkg::MODE_W-1:0]  mode_ff;
   logic [ptt_pkg::ID_W-1:0]    id_ff;
   logic [ptt_pkg::IVAL_W-1:0]  ival_ff;
   logic                        slow_ff;
   logic [ptt_pkg::NOW_W-1:0]   now_ff;
   logic                        conn_ff;
   logic                        paused_ff;

   // Interval rounding unit.
   logic [ptt_pkg::IVAL_W-1:0]  div_sh_ff;
   logic [ptt_pkg::REM_W-1:0]   rem_ff;
   logic [ptt_pkg::REM_W-1:0]   rem_shift;
   logic [ptt_pkg::IVAL_W-1:0]  round_ff;
   logic [ptt_pkg::PER_W-1:0]   per_ms_ff;
   logic [ptt_pkg::PER20_W-1:0] per20_ff;

   // Slot table.
   logic [ptt_pkg::NUM_SLOTS-1:0] used_ff;
   logic [ptt_pkg::NUM_SLOTS-1:0] en_ff;
   logic [ptt_pkg::NUM_SLOTS-1:0] str_ff;
   logic [ptt_pkg::ID_W-1:0]      slot_id_ff    [ptt_pkg::NUM_SLOTS];
   logic [ptt_pkg::PER_W-1:0]     slot_per_ff   [ptt_pkg::NUM_SLOTS];
   logic [ptt_pkg::PER20_W-1:0]   slot_per20_ff [ptt_pkg::NUM_SLOTS];
   logic [ptt_pkg::NOW_W-1:0]     slot_dl_ff    [ptt_pkg::NUM_SLOTS];
   logic [ptt_pkg::NOW_W-1:0]     fire_period;

   // Result side.
   logic                          ok_ff;
   logic                          pend_valid_ff;
   logic [ptt_pkg::ID_W-1:0]      pend_id_ff;
   logic [ptt_pkg::FIRE_W-1:0]    fire_cnt_ff;
   logic                          out_valid_ff;
   logic [ptt_pkg::KIND_W-1:0]    out_kind_ff;
   logic                          out_ok_ff;
   logic [ptt_pkg::ID_W-1:0]      out_id_ff;
   logic                          out_last_ff;
   logic [ptt_pkg::KIND_W-1:0]    ack_kind;

   // Unpack the request data.
   assign req_mode   = req_tdata[2:0];
   assign req_id     = req_tdata[6:3];
   assign req_ival   = req_tdata[22:7];
   assign req_slow   = req_tdata[23];
   assign req_now    = req_tdata[55:24];
   assign req_conn   = req_tdata[56];
   assign req_paused = req_tdata[57];

   // A granularity of zero counts as one; short intervals are raised to it.
   assign gran_eff = (gran_ff == '0) ? ptt_pkg::GRAN_W'(1) : gran_ff;
   assign raised   = (req_ival < ptt_pkg::IVAL_W'(gran_eff)) ?
                     ptt_pkg::IVAL_W'(gran_eff) : req_ival;

   // Granularity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         gran_ff <= ptt_pkg::GRAN_RESET;
      end else if (csr_wr_en) begin
         gran_ff <= csr_wr_data;
      end
   end

   // Item capture and the restoring remainder, one dividend bit a cycle.
   assign rem_shift = {rem_ff[ptt_pkg::REM_W-2:0], div_sh_ff[ptt_pkg::IVAL_W-1]};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= req_mode;
         id_ff     <= req_id;
         ival_ff   <= raised;
         slow_ff   <= req_slow;
         now_ff    <= req_now;
         conn_ff   <= req_conn;
         paused_ff <= req_paused;
         div_sh_ff <= raised;
         rem_ff    <= '0;
      end else if (cmd.div_step) begin
         div_sh_ff <= {div_sh_ff[ptt_pkg::IVAL_W-2:0], 1'b0};
         if (rem_shift >= ptt_pkg::REM_W'(gran_eff)) begin
            rem_ff <= rem_shift - ptt_pkg::REM_W'(gran_eff);
         end else begin
            rem_ff <= rem_shift;
         end
      end
      if (cmd.sub_en) begin
         round_ff <= ival_ff - ptt_pkg::IVAL_W'(rem_ff);
      end
      if (cmd.mul_en) begin
         per_ms_ff <= ptt_pkg::PER_W'(round_ff) * ptt_pkg::PER_W'(ptt_pkg::MS_PER_S);
      end
      if (cmd.str_en) begin
         per20_ff <= ptt_pkg::PER20_W'(per_ms_ff) *
                     ptt_pkg::PER20_W'(ptt_pkg::STRETCH_FACTOR);
      end
   end

   // Occupied and armed flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         en_ff   <= '0;
      end else begin
         if (cmd.slot_add) begin
            used_ff[cmd.idx] <= 1'b1;
            en_ff[cmd.idx]   <= 1'b0;
         end
         if (cmd.slot_remove) begin
            used_ff[cmd.idx] <= 1'b0;
            en_ff[cmd.idx]   <= 1'b0;
         end
         if (cmd.slot_enable) begin
            en_ff[cmd.idx] <= 1'b1;
         end
         if (cmd.slot_disable) begin
            en_ff[cmd.idx] <= 1'b0;
         end
      end
   end

   // The stretched period applies while disconnected, to slots added with slowdown.
   assign fire_period = (!conn_ff && str_ff[cmd.idx]) ?
                        ptt_pkg::NOW_W'(slot_per20_ff[cmd.idx]) :
                        ptt_pkg::NOW_W'(slot_per_ff[cmd.idx]);

   // Slot payload and deadlines.
   always_ff @(posedge clock) begin
      if (cmd.slot_add) begin
         slot_id_ff[cmd.idx]    <= id_ff;
         slot_per_ff[cmd.idx]   <= per_ms_ff;
         slot_per20_ff[cmd.idx] <= per20_ff;
         str_ff[cmd.idx]        <= slow_ff;
      end
      if (cmd.slot_enable) begin
         slot_dl_ff[cmd.idx] <= now_ff + ptt_pkg::NOW_W'(slot_per_ff[cmd.idx]);
      end
      if (cmd.slot_fire) begin
         slot_dl_ff[cmd.idx] <= now_ff + fire_period;
      end
   end

   // Success flag, held fired item and fired count of the current item.
   always_ff @(posedge clock) begin
      if (reset) begin
         ok_ff         <= 1'b0;
         pend_valid_ff <= 1'b0;
         fire_cnt_ff   <= '0;
      end else if (cmd.load) begin
         ok_ff         <= 1'b0;
         pend_valid_ff <= 1'b0;
         fire_cnt_ff   <= '0;
      end else begin
         if (cmd.set_ok) begin
            ok_ff <= 1'b1;
         end
         if (cmd.slot_fire) begin
            pend_valid_ff <= 1'b1;
            fire_cnt_ff   <= fire_cnt_ff + 1'b1;
         end else if (cmd.push_final) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.slot_fire) begin
         pend_id_ff <= slot_id_ff[cmd.idx];
      end
   end

   // Acknowledge kind follows the operation.
   always_comb begin
      case (mode_ff)
         ptt_pkg::MODE_ADD:    ack_kind = ptt_pkg::KIND_ADD;
         ptt_pkg::MODE_REMOVE: ack_kind = ptt_pkg::KIND_REMOVE;
         default:              ack_kind = ptt_pkg::KIND_ENDIS;
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.push_ack || cmd.push_fire || cmd.push_final) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_ack) begin
         out_kind_ff <= ack_kind;
         out_ok_ff   <= ok_ff;
         out_id_ff   <= '0;
         out_last_ff <= 1'b1;
      end else if (cmd.push_fire || cmd.push_final) begin
         out_kind_ff <= ptt_pkg::KIND_FIRED;
         out_ok_ff   <= 1'b0;
         out_id_ff   <= pend_id_ff;
         out_last_ff <= cmd.push_final;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {1'b0, out_id_ff, out_ok_ff, out_kind_ff};

   // Status toward the controller.
   always_comb begin
      stat.req_mode    = req_mode;
      stat.mode        = mode_ff;
      stat.paused      = paused_ff;
      stat.cur_used    = used_ff[cmd.idx];
      stat.cur_enabled = en_ff[cmd.idx];
      stat.cur_match   = (slot_id_ff[cmd.idx] == id_ff);
      stat.cur_due     = (now_ff >= slot_dl_ff[cmd.idx]);
      stat.pend_valid  = pend_valid_ff;
      stat.fire_full   = (fire_cnt_ff == ptt_pkg::FIRE_W'(ptt_pkg::MAX_RESULTS));
      stat.out_free    = ~out_valid_ff | rsp_tready;
   end

endmodule

`default_nettype wire

@@ sv/periodic_task_timer_table.sv @@
// ----------------------------------------------------------------------------
// Periodic task timer table
// A table of periodic tasks: add, remove, enable all, disable all and a
// tick that fires every due task and rearms it, or disarms every task when paused.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_tvalid/tready     tdata: mode, task_id, interval_s,
//                                             slowdown, now_ms, connected, paused
//   rsp      out        rsp_tvalid/tready     tdata: kind, ok, fired_id; tlast
//   csr      in         csr_wr_en             csr_wr_data: granularity_s
//
// Items are taken one at a time. The slot scan visits one slot a cycle, except
// while a tick waits for the output register; add first runs the remainder
// unit, then rounds down, scales to milliseconds and stretches the period.
// Each fired task past the first waits for the output register to drain.
// Reset empties the table and sets the granularity to one second.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_timer_table (
   input  wire                                clock,
   input  wire                                reset,
   // Granularity register write.
   input  wire                                csr_wr_en,
   input  wire  [ptt_pkg::GRAN_W-1:0]         csr_wr_data,
   // Request stream.
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: mode[3], task_id[4], interval_s[16], slowdown[1],
   // now_ms[32], connected[1], paused[1], zero fill[6].
   input  wire  [ptt_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // Response stream.
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // Fields from bit 0: kind[2], ok[1], fired_id[4], zero fill[1].
   output logic [ptt_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast
);

   ptt_pkg::ptt_cmd_type  cmd;
   ptt_pkg::ptt_stat_type stat;

   // Sequencer.
   ptt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Table, arithmetic and output register.
   ptt_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Periodic task timer table: self-checking testbench
// Drives add, remove, enable, disable and tick items into the request stream
// and keeps its own copy of the task table and the granularity register. Each
// item accepted by the block updates that copy and queues the acknowledges
// and task firings that it must produce. Every response item is compared,
// field by field, against the oldest queued one. A directed pass covers the
// corner cases. A random pass follows with idle gaps on both streams, a long
// output stall and granularity changes between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   localparam int HALF_PERIOD    = 2;
   localparam int RESET_CYCLES   = 4;
   localparam int SETTLE_CYCLES  = 64;
   localparam int IDLE_LIMIT     = 3000;
   localparam int IDLE_PCT       = 15;
   localparam int HOLD_CYCLES    = 400;
   localparam int PRESSURE_ITEMS = 20;
   localparam int RANDOM_ITEMS   = 100;
   localparam int REGRAN_EVERY   = 35;

   // Mode values that the block ignores.
   localparam logic [ptt_pkg::MODE_W-1:0] MODE_UNUSED = 3'd5;

   // Fields of one request item.
   typedef struct {
      logic [ptt_pkg::MODE_W-1:0] mode;
      logic [ptt_pkg::ID_W-1:0]   task_id;
      logic [ptt_pkg::IVAL_W-1:0] interval_s;
      logic                       slowdown;
      logic [ptt_pkg::NOW_W-1:0]  now_ms;
      logic                       connected;
      logic                       paused;
   } timer_cmd_type;

   // Fields of one response item.
   typedef struct {
      logic [ptt_pkg::KIND_W-1:0] kind;
      logic                       ok;
      logic [ptt_pkg::ID_W-1:0]   fired_id;
      logic                       last;
   } timer_reply_type;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            csr_wr_en   = 1'b0;
   logic [ptt_pkg::GRAN_W-1:0]      csr_wr_data = '0;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [ptt_pkg::REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [ptt_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;

   // Table copy kept in step with the block.
   logic [ptt_pkg::GRAN_W-1:0]      gran_s = ptt_pkg::GRAN_RESET;
   bit                              slot_busy[ptt_pkg::NUM_SLOTS];
   logic [ptt_pkg::ID_W-1:0]        slot_owner[ptt_pkg::NUM_SLOTS];
   logic [ptt_pkg::PER_W-1:0]       slot_period[ptt_pkg::NUM_SLOTS];
   bit                              slot_slow[ptt_pkg::NUM_SLOTS];
   bit                              slot_armed[ptt_pkg::NUM_SLOTS];
   logic [ptt_pkg::NOW_W-1:0]       slot_due[ptt_pkg::NUM_SLOTS];

   timer_reply_type                 reply_q[$];
   int                              failures     = 0;
   int                              quiet_cycles = 0;
   int                              backlog_hold = 0;
   bit                              steady       = 1'b0;
   logic [ptt_pkg::NOW_W-1:0]       wall_ms;

   periodic_task_timer_table dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   // Free-running clock.
   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Apply one accepted item to the table copy and queue the replies it owes.
   function automatic void apply_timer_op(input timer_cmd_type c);
      int unsigned     g;
      int unsigned     ival;
      logic [31:0]     per;
      bit              done;
      timer_reply_type ack;
      timer_reply_type fired[$];
      done = 1'b0;
      ack  = '{kind: ptt_pkg::KIND_ADD, ok: 1'b0, fired_id: '0, last: 1'b1};
      case (c.mode)
         ptt_pkg::MODE_ADD: begin
            g    = (gran_s == '0) ? 1 : gran_s;
            ival = c.interval_s;
            if (ival < g) ival = g;
            ival = ival - (ival % g);
            for (int i = 0; i < ptt_pkg::NUM_SLOTS; i++) begin
               if (!done && !slot_busy[i]) begin
                  slot_busy[i]   = 1'b1;
                  slot_owner[i]  = c.task_id;
                  slot_period[i] = ptt_pkg::PER_W'(ival * ptt_pkg::MS_PER_S);
                  slot_slow[i]   = c.slowdown;
                  slot_armed[i]  = 1'b0;
                  slot_due[i]    = '0;
                  done           = 1'b1;
               end
            end
            ack.ok = done;
            reply_q.push_back(ack);
         end
         ptt_pkg::MODE_REMOVE: begin
            for (int i = 0; i < ptt_pkg::NUM_SLOTS; i++) begin
               if (!done && slot_busy[i] && slot_owner[i] == c.task_id) begin
                  slot_busy[i]  = 1'b0;
                  slot_armed[i] = 1'b0;
                  done          = 1'b1;
               end
            end
            ack.kind = ptt_pkg::KIND_REMOVE;
            ack.ok   = done;
            reply_q.push_back(ack);
         end
         ptt_pkg::MODE_ENABLE, ptt_pkg::MODE_DISABLE: begin
            for (int i = 0; i < ptt_pkg::NUM_SLOTS; i++) begin
               if (slot_busy[i]) begin
                  slot_armed[i] = (c.mode == ptt_pkg::MODE_ENABLE);
                  if (c.mode == ptt_pkg::MODE_ENABLE)
                     slot_due[i] = c.now_ms + slot_period[i];
               end
            end
            ack.kind = ptt_pkg::KIND_ENDIS;
            reply_q.push_back(ack);
         end
         ptt_pkg::MODE_TICK: begin
            // A paused machine only disarms; otherwise fire in slot order.
            for (int i = 0; i < ptt_pkg::NUM_SLOTS; i++) begin
               if (slot_busy[i] && c.paused) begin
                  slot_armed[i] = 1'b0;
               end else if (slot_busy[i] && slot_armed[i] && c.now_ms >= slot_due[i] &&
                            fired.size() < ptt_pkg::MAX_RESULTS) begin
                  per = slot_period[i];
                  if (!c.connected && slot_slow[i]) per = per * ptt_pkg::STRETCH_FACTOR;
                  slot_due[i] = c.now_ms + per;
                  fired.push_back('{kind: ptt_pkg::KIND_FIRED, ok: 1'b0,
                                    fired_id: slot_owner[i], last: 1'b0});
               end
            end
            if (fired.size() > 0) fired[fired.size() - 1].last = 1'b1;
            foreach (fired[k]) reply_q.push_back(fired[k]);
         end
         default: begin
         end
      endcase
   endfunction

   function automatic timer_cmd_type make_cmd(input logic [ptt_pkg::MODE_W-1:0] mode,
                                              input logic [ptt_pkg::ID_W-1:0] id,
                                              input logic [ptt_pkg::IVAL_W-1:0] ival,
                                              input logic slow,
                                              input logic [ptt_pkg::NOW_W-1:0] now,
                                              input logic conn,
                                              input logic paused);
      timer_cmd_type c;
      c = '{mode: mode, task_id: id, interval_s: ival, slowdown: slow, now_ms: now,
            connected: conn, paused: paused};
      return c;
   endfunction

   // Mostly short periods so that ticks fire often, some long ones.
   function automatic logic [ptt_pkg::IVAL_W-1:0] pick_interval();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) return ptt_pkg::IVAL_W'($urandom_range(12, 1));
      if (roll < 90) return ptt_pkg::IVAL_W'($urandom_range(200));
      return ptt_pkg::IVAL_W'($urandom);
   endfunction

   function automatic logic [ptt_pkg::GRAN_W-1:0] pick_granularity();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 15) return '0;
      if (roll < 30) return '1;
      if (roll < 45) return ptt_pkg::GRAN_RESET;
      return ptt_pkg::GRAN_W'($urandom_range(8, 1));
   endfunction

   // Offer one item, wait for the handshake and predict its replies.
   task automatic send_item(input timer_cmd_type c);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, c.paused, c.connected, c.now_ms, c.slowdown, c.interval_s,
                     c.task_id, c.mode};
      do @(posedge clock); while (req_tready !== 1'b1);
      apply_timer_op(c);
   endtask

   // Stop offering items and let the block finish all of its work.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (reply_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_granularity(input logic [ptt_pkg::GRAN_W-1:0] g);
      drain_block();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= g;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      gran_s       = g;
   endtask

   // One item of random traffic; noise and ignored modes are mixed in.
   task automatic send_random_op(output bit counted);
      timer_cmd_type c;
      int unsigned   roll;
      roll = $urandom_range(99);
      c = make_cmd(ptt_pkg::MODE_TICK, ptt_pkg::ID_W'($urandom), pick_interval(),
                   1'($urandom), wall_ms, 1'($urandom), 1'b0);
      if (roll < 8) begin
         c.mode       = ptt_pkg::MODE_W'($urandom);
         c.interval_s = ptt_pkg::IVAL_W'($urandom);
         c.now_ms     = $urandom;
         c.paused     = 1'($urandom);
      end else if (roll < 28) begin
         c.mode = ptt_pkg::MODE_ADD;
      end else if (roll < 40) begin
         c.mode = ptt_pkg::MODE_REMOVE;
      end else if (roll < 50) begin
         c.mode = ptt_pkg::MODE_ENABLE;
      end else if (roll < 55) begin
         c.mode = ptt_pkg::MODE_DISABLE;
      end else begin
         // Time moves forward between ticks and now and then jumps anywhere.
         wall_ms = wall_ms + $urandom_range(15000);
         if (roll >= 96) wall_ms = $urandom;
         c.now_ms = wall_ms;
         c.paused = (roll < 60);
      end
      send_item(c);
      counted = (c.mode <= ptt_pkg::MODE_TICK);
   endtask

   task automatic test_empty_table();
      send_item(make_cmd(ptt_pkg::MODE_REMOVE, 4'd5, '0, 1'b0, '0, 1'b1, 1'b0));
      send_item(make_cmd(ptt_pkg::MODE_TICK, '0, '0, 1'b0, '1, 1'b1, 1'b0));
      send_item(make_cmd(MODE_UNUSED, '1, '1, 1'b1, '1, 1'b1, 1'b1));
   endtask

   // Zero granularity, intervals raised and rounded down, duplicate ids.
   task automatic test_interval_rounding();
      write_granularity('0);
      send_item(make_cmd(ptt_pkg::MODE_ADD, 4'd0, '0, 1'b0, '0, 1'b1, 1'b0));
      write_granularity(6'd60);
      send_item(make_cmd(ptt_pkg::MODE_ADD, 4'd15, 16'd59, 1'b1, '0, 1'b1, 1'b0));
      send_item(make_cmd(ptt_pkg::MODE_ADD, 4'd15, '1, 1'b0, '0, 1'b1, 1'b0));
      write_granularity('1);
      send_item(make_cmd(ptt_pkg::MODE_ADD, 4'd3, '1, 1'b1, '0, 1'b1, 1'b0));
   endtask

   // Deadlines that wrap past zero, stretched rearm, paused and idle ticks.
   task automatic test_fire_and_wrap();
      send_item(make_cmd(ptt_pkg::MODE_ENABLE, '0, '0, 1'b0, 32'hFFFF_F000, 1'b1, 1'b0));
      send_item(make_cmd(ptt_pkg::MODE_TICK, '0, '0, 1'b0, '1, 1'b0, 1'b0));
      send_item(make_cmd(ptt_pkg::MODE_TICK, '0, '0, 1'b0, '1, 1'b1, 1'b1));
      send_item(make_cmd(ptt_pkg::MODE_TICK, '0, '0, 1'b0, '1, 1'b1, 1'b0));
      send_item(make_cmd(ptt_pkg::MODE_DISABLE, '0, '0, 1'b0, '0, 1'b1, 1'b0));
   endtask

   task automatic test_remove_duplicates();
      send_item(make_cmd(ptt_pkg::MODE_REMOVE, 4'd15, '0, 1'b0, '0, 1'b1, 1'b0));
      send_item(make_cmd(ptt_pkg::MODE_REMOVE, 4'd9, '0, 1'b0, '0, 1'b1, 1'b0));
   endtask

   // Fill every free slot, overflow once, then fire the whole table.
   task automatic test_full_table();
      for (int k = 0; k < ptt_pkg::NUM_SLOTS; k++) begin
         if (!slot_busy[k])
            send_item(make_cmd(ptt_pkg::MODE_ADD, ptt_pkg::ID_W'(k), ptt_pkg::IVAL_W'(k),
                               1'(k), '0, 1'b1, 1'b0));
      end
      send_item(make_cmd(ptt_pkg::MODE_ADD, 4'd7, 16'd2, 1'b0, '0, 1'b1, 1'b0));
      send_item(make_cmd(ptt_pkg::MODE_ENABLE, '0, '0, 1'b0, '0, 1'b1, 1'b0));
      send_item(make_cmd(ptt_pkg::MODE_TICK, '0, '0, 1'b0, '1, 1'b0, 1'b0));
   endtask

   // The receiver stops for a long stretch while items keep coming.
   task automatic test_output_backpressure();
      bit counted;
      backlog_hold = HOLD_CYCLES;
      repeat (PRESSURE_ITEMS) send_random_op(counted);
   endtask

   task automatic test_random_traffic();
      bit counted;
      int sent;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         steady = (sent >= 50 && sent < 90);
         send_random_op(counted);
         if (counted) begin
            sent++;
            if (sent % REGRAN_EVERY == 0) write_granularity(pick_granularity());
         end
      end
      steady = 1'b0;
   endtask

   // Response side: random stalls, plus a long hold when one is requested.
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (backlog_hold > 0) begin
            n            = backlog_hold;
            backlog_hold = 0;
            rsp_tready  <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Compare each accepted response item with the oldest predicted one.
   always @(posedge clock) begin
      timer_reply_type e;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (reply_q.size() == 0) begin
            $error("unexpected item: tdata %h tlast %b", rsp_tdata, rsp_tlast);
            failures++;
         end else begin
            e = reply_q.pop_front();
            if (rsp_tdata[1:0] !== e.kind) begin
               $error("kind: expected %0d, got %0d", e.kind, rsp_tdata[1:0]);
               failures++;
            end
            if (rsp_tdata[2] !== e.ok) begin
               $error("ok: expected %0d, got %0d", e.ok, rsp_tdata[2]);
               failures++;
            end
            if (rsp_tdata[6:3] !== e.fired_id) begin
               $error("fired_id: expected %0d, got %0d", e.fired_id, rsp_tdata[6:3]);
               failures++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last: expected %0d, got %0d", e.last, rsp_tlast);
               failures++;
            end
         end
      end
   end

   // Watchdog: too long without any item moving on either stream.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      wall_ms = $urandom;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_interval_rounding();
      test_fire_and_wrap();
      test_remove_duplicates();
      test_full_table();
      test_output_backpressure();
      test_random_traffic();
      drain_block();
      if (failures == 0 && reply_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire

@@ periodic_task_timer_table.f @@
sv/ptt_pkg.sv
sv/ptt_ctrl.sv
sv/ptt_dp.sv
sv/periodic_task_timer_table.sv
dv/tb_top.sv
